@@ rtl/core/mbfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mbfs_pkg
// Shared types and constants of the metaball field sum block: stream field
// layout, register map, datapath widths, controller states and commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbfs_pkg;

    // Input item kinds, carried on s_axis_tuser.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Field widths.
    localparam int SLOT_W  = 4;
    localparam int COORD_W = 16;
    localparam int COUNT_W = 5;
    localparam int FIELD_W = 32;

    // Slave tdata layout, lowest bits first.
    localparam int S_TDATA_W  = 72;
    localparam int SLOT_LSB   = 0;
    localparam int POS_X_LSB  = SLOT_LSB + SLOT_W;
    localparam int POS_Y_LSB  = POS_X_LSB + COORD_W;
    localparam int POS_Z_LSB  = POS_Y_LSB + COORD_W;
    localparam int RADIUS_LSB = POS_Z_LSB + COORD_W;
    localparam int S_USED_W   = RADIUS_LSB + COORD_W;

    // Register map.
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_BALL_COUNT = 2'd0;

    // Datapath widths. The denominator is the sum of three 17-bit squares and
    // one 16-bit square; the dividend 2^32 is walked over the same width.
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int RSQ_W     = 2 * COORD_W;
    localparam int DEN_W     = 34;
    localparam int DIV_BITS  = 2;
    localparam int DIV_CYCLES = DEN_W / DIV_BITS;
    localparam int DIV_STEP_W = $clog2(DIV_CYCLES);
    localparam logic [DIV_STEP_W-1:0] DIV_LAST = DIV_STEP_W'(DIV_CYCLES - 1);
    localparam logic [DEN_W-1:0] DIVIDEND = DEN_W'(64'h1_0000_0000);
    localparam logic [FIELD_W-1:0] SAT32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [COORD_W-1:0] rad;
        logic [COORD_W-1:0] cz;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cx;
    } t_ball;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_DENOM,
        ST_DIVIDE,
        ST_ACCUM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic ball_write;
        logic query_start;
        logic rd_en;
        logic sq_load;
        logic den_load;
        logic div_step;
        logic acc_load;
        logic out_load;
    } t_cmd;

endpackage

@@ rtl/core/metaball_field_sum_top.sv @@
// ----------------------------------------------------------------------------
// metaball_field_sum_top
// Metaball field evaluator. A load transfer (tuser = 0) writes one ball,
// a signed Q8.8 center and an unsigned Q8.8 radius, into a table slot; a
// query transfer (tuser = 1) gives a point and returns, as one result
// transfer, the sum over the first ball_count slots of
// 1 / (dx^2 + dy^2 + dz^2 + r^2) in unsigned Q16.16. A term with a zero
// denominator or a value of 2^32 and above, and a sum above 0xFFFFFFFF,
// saturate to 0xFFFFFFFF and set the saturated flag. A load produces
// nothing. A query holds the input side until its result is registered; it
// walks n balls, n being ball_count clamped to MAX_BALLS: each ball costs a
// table read, a squaring stage, a denominator stage, the two-bit per cycle
// reciprocal divider and an accumulate. The result waits in an output
// register, so the next item is accepted while it is still untaken. Every
// slot in use must have been loaded since reset, since the table has no
// clearing pass. The user must write ball_count over the APB port only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module metaball_field_sum_top #(
    parameter int MAX_BALLS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input items.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot[3:0], pos_x[19:4], pos_y[35:20], pos_z[51:36], ball_radius[67:52]
    input  logic [mbfs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // kind[0]
    input  logic                            s_axis_tuser,
    // Results.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // field_value[31:0]
    output logic [mbfs_pkg::FIELD_W-1:0]    m_axis_tdata,
    // saturated[0]
    output logic                            m_axis_tuser,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbfs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mbfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mbfs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    import mbfs_pkg::*;

    localparam int AW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;

    logic [COUNT_W-1:0] r_ball_count;
    logic               cfg_write;
    t_cmd               cmd;
    logic [AW-1:0]      rd_addr;

    // The only register is ball_count; the write completes in the access
    // phase, and pready is tied high so there are no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_BALL_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ball_count <= '0;
        end else if (cfg_write) begin
            r_ball_count <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_BALL_COUNT) begin
            prdata = APB_DATA_W'(r_ball_count);
        end
    end

    // The controller sequences the walk over the table; the datapath holds
    // the table, the arithmetic and the result register.
    mbfs_ctrl #(
        .MAX_BALLS (MAX_BALLS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_kind       (s_axis_tuser),
        .o_in_ready   (s_axis_tready),
        .i_ball_count (r_ball_count),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_cmd        (cmd),
        .o_rd_addr    (rd_addr)
    );

    mbfs_dp #(
        .MAX_BALLS (MAX_BALLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_slot        (s_axis_tdata[SLOT_LSB +: SLOT_W]),
        .i_pos_x       (s_axis_tdata[POS_X_LSB +: COORD_W]),
        .i_pos_y       (s_axis_tdata[POS_Y_LSB +: COORD_W]),
        .i_pos_z       (s_axis_tdata[POS_Z_LSB +: COORD_W]),
        .i_ball_radius (s_axis_tdata[RADIUS_LSB +: COORD_W]),
        .i_rd_addr     (rd_addr),
        .o_field_value (m_axis_tdata),
        .o_saturated   (m_axis_tuser)
    );

endmodule

@@ rtl/core/mbfs_ram.sv @@
// ----------------------------------------------------------------------------
// mbfs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/mbfs_dp.sv @@
// ----------------------------------------------------------------------------
// mbfs_dp
// Datapath: ball table, squared distances, denominator, radix-4 restoring
// reciprocal and the saturating field accumulator with its result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbfs_dp #(
    parameter int MAX_BALLS = 16,
    localparam int AW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1
) (
    input  logic                         i_clk,
    input  mbfs_pkg::t_cmd               i_cmd,
    input  logic [mbfs_pkg::SLOT_W-1:0]  i_slot,
    input  logic [mbfs_pkg::COORD_W-1:0] i_pos_x,
    input  logic [mbfs_pkg::COORD_W-1:0] i_pos_y,
    input  logic [mbfs_pkg::COORD_W-1:0] i_pos_z,
    input  logic [mbfs_pkg::COORD_W-1:0] i_ball_radius,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [mbfs_pkg::FIELD_W-1:0] o_field_value,
    output logic                         o_saturated
);

    import mbfs_pkg::*;

    localparam int CW   = $clog2(MAX_BALLS + 1);
    localparam int ChkW = (CW > SLOT_W) ? CW : SLOT_W;

    logic             wr_en;
    t_ball            wr_ball;
    logic [$bits(t_ball)-1:0] rd_data;
    t_ball            ball;

    logic [COORD_W-1:0] r_px, r_py, r_pz;
    logic [SQ_W-1:0]    r_sqx, r_sqy, r_sqz;
    logic [RSQ_W-1:0]   r_sqr;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem, r_dvd, r_quo;
    logic [FIELD_W-1:0] r_acc;
    logic               r_acc_sat;
    logic [FIELD_W-1:0] r_field;
    logic               r_sat;

    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic [DIFF_W-1:0]        ax, ay, az;
    logic [DEN_W-1:0]         rem_v, dvd_v, quo_v;
    logic [DEN_W:0]           trial;
    logic                     term_sat;
    logic [FIELD_W-1:0]       term;
    logic [FIELD_W:0]         sum;

    // Loads to a slot beyond the table are dropped.
    assign wr_en   = i_cmd.ball_write && (ChkW'(i_slot) < ChkW'(MAX_BALLS));
    assign wr_ball = '{rad: i_ball_radius, cz: i_pos_z, cy: i_pos_y, cx: i_pos_x};

    mbfs_ram #(
        .WIDTH ($bits(t_ball)),
        .DEPTH (MAX_BALLS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_slot)),
        .i_wr_data (wr_ball),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (rd_data)
    );

    assign ball = t_ball'(rd_data);

    // Exact 17-bit differences and their magnitudes.
    assign dx = DIFF_W'($signed(r_px)) - DIFF_W'($signed(ball.cx));
    assign dy = DIFF_W'($signed(r_py)) - DIFF_W'($signed(ball.cy));
    assign dz = DIFF_W'($signed(r_pz)) - DIFF_W'($signed(ball.cz));
    assign ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    assign ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    assign az = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);

    // Two restoring steps per cycle on the quotient of 2^32 by the denominator.
    always_comb begin
        rem_v = r_rem;
        dvd_v = r_dvd;
        quo_v = r_quo;
        trial = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial = {rem_v, dvd_v[DEN_W-1]};
            dvd_v = {dvd_v[DEN_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                rem_v = DEN_W'(trial - {1'b0, r_den});
                quo_v = {quo_v[DEN_W-2:0], 1'b1};
            end else begin
                rem_v = trial[DEN_W-1:0];
                quo_v = {quo_v[DEN_W-2:0], 1'b0};
            end
        end
    end

    // A zero denominator or a quotient of 2^32 and above saturates the term.
    assign term_sat = (r_den == '0) || (r_quo[DEN_W-1:FIELD_W] != '0);
    assign term     = term_sat ? SAT32 : r_quo[FIELD_W-1:0];
    assign sum      = {1'b0, r_acc} + {1'b0, term};

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_px      <= i_pos_x;
            r_py      <= i_pos_y;
            r_pz      <= i_pos_z;
            r_acc     <= '0;
            r_acc_sat <= 1'b0;
        end
        if (i_cmd.sq_load) begin
            r_sqx <= ax * ax;
            r_sqy <= ay * ay;
            r_sqz <= az * az;
            r_sqr <= ball.rad * ball.rad;
        end
        if (i_cmd.den_load) begin
            r_den <= DEN_W'(r_sqx) + DEN_W'(r_sqy) + DEN_W'(r_sqz) + DEN_W'(r_sqr);
            r_rem <= '0;
            r_dvd <= DIVIDEND;
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_v;
            r_dvd <= dvd_v;
            r_quo <= quo_v;
        end
        if (i_cmd.acc_load) begin
            r_acc     <= sum[FIELD_W] ? SAT32 : sum[FIELD_W-1:0];
            r_acc_sat <= r_acc_sat | term_sat | sum[FIELD_W];
        end
        if (i_cmd.out_load) begin
            r_field <= r_acc;
            r_sat   <= r_acc_sat;
        end
    end

    assign o_field_value = r_field;
    assign o_saturated   = r_sat;

endmodule

@@ rtl/core/mbfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mbfs_ctrl
// Controller: accepts items, walks the table slots in use for a query,
// sequences the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbfs_ctrl #(
    parameter int MAX_BALLS = 16,
    localparam int AW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_kind,
    output logic                         o_in_ready,
    input  logic [mbfs_pkg::COUNT_W-1:0] i_ball_count,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output mbfs_pkg::t_cmd               o_cmd,
    output logic [AW-1:0]                o_rd_addr
);

    import mbfs_pkg::*;

    localparam int CW   = $clog2(MAX_BALLS + 1);
    localparam int CmpW = CW + 1;
    localparam int BcW  = (CW > COUNT_W) ? CW : COUNT_W;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_count, n_count;
    logic [DIV_STEP_W-1:0] r_step, n_step;
    logic                  r_out_valid, n_out_valid;
    t_cmd                  cmd;
    logic                  in_ready;
    logic [BcW-1:0]        bc_ext;
    logic [CW-1:0]         count_used;
    logic                  last_ball;

    // A count beyond the table is clamped to the table depth.
    assign bc_ext     = BcW'(i_ball_count);
    assign count_used = (bc_ext > BcW'(MAX_BALLS)) ? CW'(MAX_BALLS) : CW'(bc_ext);
    assign last_ball  = (CmpW'(r_idx) + CmpW'(1)) == CmpW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        cmd         = '0;
        in_ready    = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_kind == KIND_LOAD) begin
                        cmd.ball_write = 1'b1;
                    end else begin
                        cmd.query_start = 1'b1;
                        n_idx           = '0;
                        n_count         = count_used;
                        n_state         = (count_used == '0) ? ST_DONE : ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
                n_state   = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.sq_load = 1'b1;
                n_state     = ST_DENOM;
            end
            ST_DENOM: begin
                cmd.den_load = 1'b1;
                n_step       = DIV_LAST;
                n_state      = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_ACCUM;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_ACCUM: begin
                cmd.acc_load = 1'b1;
                if (last_ball) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_rd_addr   = r_idx;

    // A new result never overwrites one that has not been taken.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register loaded while holding an untaken result");

    // The walk stays inside the slots in use.
    a_idx_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ || r_state == ST_SQUARE || r_state == ST_DENOM ||
         r_state == ST_DIVIDE || r_state == ST_ACCUM)
        |-> (CmpW'(r_idx) < CmpW'(r_count)))
        else $error("table walk index beyond ball count");

    // Each reciprocal starts with a full step count.
    a_div_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DENOM |=> (r_state == ST_DIVIDE && r_step == DIV_LAST))
        else $error("divider started without a full step count");

    // After a term is added the walk either reads the next slot or finishes.
    a_accum_next : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ACCUM |=> (r_state == ST_READ || r_state == ST_DONE))
        else $error("unexpected state after accumulation");

endmodule
